>>> sv/rbm_pkg.sv
// rbm_pkg: shared constants and types for the RSA modular exponentiation block.
// No dependencies.
package rbm_pkg;
    localparam int unsigned CFG_BITS = 32;
    localparam int unsigned EXP_BITS = 32;
    // register indexes
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;
    // cell control, shared by every cell of the chain
    typedef struct packed {
        logic clr;   // start a new multiply: clear partial result
        logic dbl;   // double phase: r = 2r mod m
        logic add;   // add phase: r = r + a mod m
    } t_cell_ctl;
endpackage

>>> sv/rbm_cell.sv
// rbm_cell: one bit slice of the modular add chain; ripples carry and borrow.
// No dependencies.
module rbm_cell (
    input  logic i_r,        // partial result bit
    input  logic i_y,        // addend bit
    input  logic i_g,        // modulus bit
    input  logic i_c,        // carry in of r + y
    input  logic i_b,        // borrow in of (r + y) - m
    output logic o_s,        // sum bit
    output logic o_c,
    output logic o_d,        // difference bit
    output logic o_b
);
    logic s;
    assign s   = i_r ^ i_y ^ i_c;
    assign o_c = (i_r & i_y) | (i_c & (i_r ^ i_y));
    assign o_s = s;
    assign o_d = s ^ i_g ^ i_b;
    assign o_b = (~s & i_g) | (~(s ^ i_g) & i_b);
endmodule

>>> sv/rbm_chain.sv
// rbm_chain: row of rbm_cell slices holding partial result r, does r = (r + y) mod m.
// Depends on rbm_pkg, rbm_cell.
module rbm_chain #(
    parameter int unsigned W = 32
) (
    input  logic              i_clk,
    input  rbm_pkg::t_cell_ctl i_ctl,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_m,
    output logic [W-1:0]      o_r
);
    logic [W-1:0] r_r, n_r, y, s, d;
    logic [W:0]   c, b;
    assign y = i_ctl.dbl ? r_r : i_a;
    assign c[0] = 1'b0;
    assign b[0] = 1'b0;
    for (genvar k = 0; k < W; k++) begin : g_cell
        rbm_cell u_cell (
            .i_r(r_r[k]), .i_y(y[k]), .i_g(i_m[k]), .i_c(c[k]), .i_b(b[k]),
            .o_s(s[k]), .o_c(c[k+1]), .o_d(d[k]), .o_b(b[k+1])
        );
    end
    // sum >= m when carry out or no borrow out
    always_comb begin
        n_r = r_r;
        if (i_ctl.clr) begin
            n_r = '0;
        end else if (i_ctl.dbl || i_ctl.add) begin
            n_r = (c[W] || !b[W]) ? d : s;
        end
    end
    always_ff @(posedge i_clk) begin
        r_r <= n_r;
    end
    assign o_r = r_r;
endmodule

>>> sv/rsa_block_modexp.sv
// rsa_block_modexp: block^exponent mod modulus, square-and-multiply over a
// bit-slice chain. Range error: result word valid in the cycle after the input
// word is taken. Else (32 + ones(exponent)) modular multiplies, each a clear
// step, a double and an add step per multiplier bit and a done step. One word
// at a time; a new input word can be taken from the cycle after the result leaves.
// Reset (synchronous, i_rst_n low): modulus=1, exponent=1, idle, no output held.
module rsa_block_modexp #(
    parameter int unsigned MODULUS_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_message_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_block,
    output logic        o_range_error
);
    localparam int unsigned W  = MODULUS_BITS;
    localparam int unsigned BW = $clog2(W);
    localparam int unsigned EW = $clog2(rbm_pkg::EXP_BITS);
    localparam int unsigned CW = (W < 32) ? W : 32;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;   // acc = acc*acc
    localparam logic [2:0] S_MUL  = 3'd2;   // acc = acc*base
    localparam logic [2:0] S_DONE = 3'd3;

    logic [31:0] r_modulus, r_exponent;
    logic [2:0]  r_state;
    logic [W-1:0] r_acc, r_base, m_w, r_mb;
    logic [EW-1:0] r_ebit;
    logic [BW-1:0] r_bit;
    logic        r_phase;   // 0 double, 1 add
    logic        r_first;   // clear cycle pending
    logic        r_is_mul;  // current multiply is acc*base
    logic        r_ovalid;
    logic [31:0] r_res;
    logic        r_err;
    logic [W-1:0] in_w, prod;
    rbm_pkg::t_cell_ctl ctl;

    // config port
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            rbm_pkg::REG_MODULUS:  prdata = r_modulus;
            default:               prdata = r_exponent;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= 32'd1;
            r_exponent <= 32'd1;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (paddr[2])
                rbm_pkg::REG_MODULUS:  r_modulus  <= pwdata;
                default:               r_exponent <= pwdata;
            endcase
        end
    end

    // datapath width cut or extend
    always_comb begin
        m_w  = '0;
        in_w = '0;
        m_w[CW-1:0]  = r_modulus[CW-1:0];
        in_w[CW-1:0] = i_message_block[CW-1:0];
    end

    // multiplicand is acc for square, base for multiply; multiplier bits walk r_mb
    always_comb begin
        ctl.clr = r_first;
        ctl.dbl = !r_first && !r_phase && (r_state == S_SQ || r_state == S_MUL);
        ctl.add = !r_first && r_phase && r_mb[r_bit];
    end

    rbm_chain #(.W(W)) u_chain (
        .i_clk(i_clk), .i_ctl(ctl),
        .i_a(r_state == S_MUL ? r_base : r_acc),
        .i_m(m_w), .o_r(prod)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_result_block = r_res;
    assign o_range_error  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_first  <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        if (m_w == '0 || in_w >= m_w) begin
                            r_res    <= '0;
                            r_err    <= 1'b1;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_base  <= in_w;
                            r_acc   <= (m_w == W'(1)) ? '0 : W'(1);
                            r_ebit  <= EW'(rbm_pkg::EXP_BITS - 1);
                            r_state <= S_SQ;
                            r_first <= 1'b1;
                            r_phase <= 1'b0;
                        end
                    end
                end
                S_SQ, S_MUL: begin
                    if (r_first) begin
                        r_first  <= 1'b0;
                        r_phase  <= 1'b0;
                        r_bit    <= BW'(W - 1);
                        r_mb     <= r_acc;   // multiplier is acc in both cases
                        r_is_mul <= (r_state == S_MUL);
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (r_bit != '0) begin
                            r_bit <= r_bit - BW'(1);
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // prod holds the finished product
                    r_acc <= prod;
                    if (!r_is_mul && r_exponent[r_ebit]) begin
                        // square done, exponent bit set: multiply by base
                        r_state <= S_MUL;
                        r_first <= 1'b1;
                    end else if (r_ebit != '0) begin
                        r_ebit  <= r_ebit - EW'(1);
                        r_state <= S_SQ;
                        r_first <= 1'b1;
                    end else begin
                        r_state  <= S_IDLE;
                        r_res    <= 32'(prod);
                        r_err    <= 1'b0;
                        r_ovalid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
